// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg: shared types for the LRU key-value store
// Request/response words, front-to-back queue entry and opcodes.
// ----------------------------------------------------------------------------
package lkv_pkg;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
   localparam logic [4:0] CAP_RESET = 5'd16;
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] store_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;
endpackage

// ===== design/lkv_front.sv =====
// ----------------------------------------------------------------------------
// lkv_front: request intake
// Two-entry queue between the request port and the table engine.
// ----------------------------------------------------------------------------
module lkv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lkv_pkg::req_type req_word,
   output logic             full,
   output logic             q_valid,
   output lkv_pkg::req_type q_word,
   input  logic             q_take
);
   import lkv_pkg::*;

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       do_push;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_word  = slot_ff[0];
   assign do_push = push && !full;

   always_comb begin
      logic [1:0] c;
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      c = count_ff;
      if (q_take && q_valid) begin
         slot_in[0] = slot_ff[1];
         c = c - 2'd1;
      end
      if (do_push) begin
         slot_in[c[0]] = req_word;
         c = c + 2'd1;
      end
      count_in = c;
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) count_ff <= 2'd0;
      else count_ff <= count_in;
   end
endmodule

// ===== design/lkv_back.sv =====
// ----------------------------------------------------------------------------
// lkv_back: table engine
// Parallel key match, rank update and insert/evict, one word per cycle while
// the two-entry response queue on the output has room or is popped.
// ----------------------------------------------------------------------------
module lkv_back #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [4:0]       capacity,
   input  logic             q_valid,
   input  lkv_pkg::req_type q_word,
   output logic             q_take,
   output logic             empty,
   output lkv_pkg::rsp_type rsp_word,
   input  logic             pop
);
   import lkv_pkg::*;

   localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RW-1:0]      rank_ff [ENTRIES];
   logic [RW-1:0]      rank_in [ENTRIES];
   logic [31:0]        key_ff  [ENTRIES];
   logic [31:0]        val_ff  [ENTRIES];

   rsp_type    oq_ff [2];
   logic [1:0] oq_cnt_ff, oq_cnt_in;

   logic [ENTRIES-1:0] match, freed;
   logic               hit;
   logic [IW-1:0]      hit_idx, free_idx;
   logic               free_ok;
   logic [RW-1:0]      old_rank;
   logic [31:0]        hit_val;
   logic [8:0]         cap_eff;
   logic               go;
   rsp_type            res;

   // accept a new word while the response queue has room after this edge
   assign q_take = q_valid && (oq_cnt_ff != 2'd2 || pop);
   assign go     = q_take;
   assign empty  = (oq_cnt_ff == 2'd0);
   assign rsp_word = oq_ff[0];

   always_comb begin
      if (capacity == 5'd0) cap_eff = 9'd1;
      else if (9'(capacity) > 9'(ENTRIES)) cap_eff = 9'(ENTRIES);
      else cap_eff = 9'(capacity);
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++)
         match[i] = valid_ff[i] && (key_ff[i] == q_word.lookup_key);
   end

   always_comb begin
      hit = 1'b0; hit_idx = '0; old_rank = '0; hit_val = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit = 1'b1; hit_idx = IW'(i); old_rank = rank_ff[i]; hit_val = val_ff[i];
         end
      end
   end

   // entries evicted on a put miss (ranks that would reach capacity drop)
   always_comb begin
      for (int i = 0; i < ENTRIES; i++)
         freed[i] = valid_ff[i] && (9'(rank_ff[i]) + 9'd1 >= cap_eff);
   end

   always_comb begin
      free_ok = 1'b0; free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!(valid_ff[i] && !freed[i])) begin
            free_ok = 1'b1; free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) rank_in[i] = rank_ff[i];
      res.found      = hit;
      res.read_value = (q_word.opcode == OP_PUT) ? 32'sd0 :
                       (hit ? $signed(hit_val) : $signed(MISS_VALUE));
      if (go) begin
         if (hit) begin
            for (int i = 0; i < ENTRIES; i++)
               if (valid_ff[i] && rank_ff[i] < old_rank) rank_in[i] = rank_ff[i] + RW'(1);
            rank_in[hit_idx] = '0;
         end else if (q_word.opcode == OP_PUT) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (freed[i]) begin
                  valid_in[i] = 1'b0; rank_in[i] = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            if (free_ok) begin
               valid_in[free_idx] = 1'b1; rank_in[free_idx] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && q_word.opcode == OP_PUT) begin
         if (hit) val_ff[hit_idx] <= q_word.store_value;
         else if (free_ok) begin
            key_ff[free_idx] <= q_word.lookup_key;
            val_ff[free_idx] <= q_word.store_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= rank_in[i];
      end
   end

   // response queue
   always_comb begin
      logic [1:0] c;
      c = oq_cnt_ff;
      if (pop && !empty) c = c - 2'd1;
      if (go) c = c + 2'd1;
      oq_cnt_in = c;
   end

   always_ff @(posedge clock) begin
      if (pop && !empty) begin
         if (go && oq_cnt_ff == 2'd1) oq_ff[0] <= res;
         else oq_ff[0] <= oq_ff[1];
         if (go && oq_cnt_ff == 2'd2) oq_ff[1] <= res;
      end else if (go) begin
         if (oq_cnt_ff == 2'd0) oq_ff[0] <= res;
         else oq_ff[1] <= res;
      end
      if (reset) oq_cnt_ff <= 2'd0;
      else oq_cnt_ff <= oq_cnt_in;
   end
endmodule

// ===== design/lru_key_value_store.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_store: fully associative key-value store, LRU replacement
// Path: a request is registered in the intake queue, then its result in the table engine's response queue.
// Throughput: one word per cycle while the result queue has room or is popped.
// Reset: synchronous; clears valid bits, ranks, queues; capacity back to 16.
// No clearing pass: valid bits are flip-flops.
// ----------------------------------------------------------------------------
module lru_key_value_store #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request queue side
   input  logic             req_push,
   input  lkv_pkg::req_type req_word,
   output logic             req_full,
   // result queue side
   output logic             rsp_empty,
   output lkv_pkg::rsp_type rsp_word,
   input  logic             rsp_pop,
   // configuration port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [0:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lkv_pkg::*;

   logic [4:0] cap_ff;
   logic       q_valid, q_take;
   req_type    q_word;

   assign csr_pready = 1'b1;
   // single register at byte address 0; paddr carries word bit above it
   assign csr_prdata = (csr_paddr == REG_CAPACITY) ? {27'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CAP_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CAPACITY)
         cap_ff <= csr_pwdata[4:0];
   end

   lkv_front u_front (
      .clock, .reset,
      .push(req_push), .req_word, .full(req_full),
      .q_valid, .q_word, .q_take
   );

   lkv_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .capacity(cap_ff),
      .q_valid, .q_word, .q_take,
      .empty(rsp_empty), .rsp_word, .pop(rsp_pop)
   );

   a_no_take_empty: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("take from empty intake queue");
   a_rsp_after_take: assert property (@(posedge clock) disable iff (reset)
      q_take |=> !rsp_empty) else $error("result missing after take");
endmodule
